>>> hw/rtl/msgpk_pkg.sv
// MessagePack encoder package: command codes, format bytes and the
// queue entry type shared by the front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none
package msgpk_pkg;

  // Command codes carried on cmd_i
  typedef enum logic [3:0] {
    CMD_NIL   = 4'd0,
    CMD_BOOL  = 4'd1,
    CMD_UINT  = 4'd2,
    CMD_SINT  = 4'd3,
    CMD_F32   = 4'd4,
    CMD_STR   = 4'd5,
    CMD_ARRAY = 4'd6,
    CMD_MAP   = 4'd7,
    CMD_RAW   = 4'd8
  } cmd_e;

  // Format bytes
  localparam logic [7:0] FMT_NIL     = 8'hc0;
  localparam logic [7:0] FMT_FALSE   = 8'hc2;
  localparam logic [7:0] FMT_TRUE    = 8'hc3;
  localparam logic [7:0] FMT_F32     = 8'hca;
  localparam logic [7:0] FMT_UINT8   = 8'hcc;
  localparam logic [7:0] FMT_UINT16  = 8'hcd;
  localparam logic [7:0] FMT_UINT32  = 8'hce;
  localparam logic [7:0] FMT_UINT64  = 8'hcf;
  localparam logic [7:0] FMT_INT8    = 8'hd0;
  localparam logic [7:0] FMT_INT16   = 8'hd1;
  localparam logic [7:0] FMT_INT32   = 8'hd2;
  localparam logic [7:0] FMT_INT64   = 8'hd3;
  localparam logic [7:0] FMT_STR8    = 8'hd9;
  localparam logic [7:0] FMT_STR16   = 8'hda;
  localparam logic [7:0] FMT_STR32   = 8'hdb;
  localparam logic [7:0] FMT_ARRAY16 = 8'hdc;
  localparam logic [7:0] FMT_ARRAY32 = 8'hdd;
  localparam logic [7:0] FMT_MAP16   = 8'hde;
  localparam logic [7:0] FMT_MAP32   = 8'hdf;
  localparam logic [7:0] FIX_STR     = 8'ha0;
  localparam logic [7:0] FIX_ARRAY   = 8'h90;
  localparam logic [7:0] FIX_MAP     = 8'h80;

  // Queue depth between front and back
  localparam int unsigned QDepth = 2;

  // One classified item: format byte, payload byte count (0..8) and the
  // payload left-aligned so the next byte to send is always [63:56]
  typedef struct packed {
    logic [7:0]  fmt;
    logic [3:0]  cnt;
    logic [63:0] data;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/msgpk_front.sv
// Front end of the MessagePack encoder: classifies one command into a
// format byte plus left-aligned payload. Depends on msgpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_front (
  input  wire logic              take_i,
  input  wire logic [3:0]        cmd_i,
  input  wire logic [63:0]       value_i,
  output msgpk_pkg::entry_t      entry_o,
  output logic                   push_o
);

  logic [63:0] v;
  logic        le_7f, le_ff, le_ffff, le_ffffffff;
  logic        ge_m32, ge_m128, ge_m32k, ge_m2g;
  logic        le_31, le_15;

  assign v = value_i;

  // Range compares on the operand
  always_comb begin
    le_7f       = (v[63:7] == '0);
    le_ff       = (v[63:8] == '0);
    le_ffff     = (v[63:16] == '0);
    le_ffffffff = (v[63:32] == '0);
    le_31       = (v[63:5] == '0);
    le_15       = (v[63:4] == '0);
    ge_m32      = (v[63:5] == '1);
    ge_m128     = (v[63:7] == '1);
    ge_m32k     = (v[63:15] == '1);
    ge_m2g      = (v[63:31] == '1);
  end

  // Pick the smallest form
  always_comb begin
    entry_o = '{fmt: 8'h00, cnt: 4'd0, data: 64'h0};
    push_o  = take_i;
    unique case (cmd_i)
      msgpk_pkg::CMD_NIL:  entry_o.fmt = msgpk_pkg::FMT_NIL;
      msgpk_pkg::CMD_BOOL: entry_o.fmt = (v != '0) ? msgpk_pkg::FMT_TRUE
                                                   : msgpk_pkg::FMT_FALSE;
      msgpk_pkg::CMD_UINT, msgpk_pkg::CMD_SINT: begin
        if (!v[63] || cmd_i == msgpk_pkg::CMD_UINT) begin
          if (le_7f) begin
            entry_o.fmt = v[7:0];
          end else if (le_ff) begin
            entry_o = '{fmt: msgpk_pkg::FMT_UINT8, cnt: 4'd1, data: {v[7:0], 56'h0}};
          end else if (le_ffff) begin
            entry_o = '{fmt: msgpk_pkg::FMT_UINT16, cnt: 4'd2, data: {v[15:0], 48'h0}};
          end else if (le_ffffffff) begin
            entry_o = '{fmt: msgpk_pkg::FMT_UINT32, cnt: 4'd4, data: {v[31:0], 32'h0}};
          end else begin
            entry_o = '{fmt: msgpk_pkg::FMT_UINT64, cnt: 4'd8, data: v};
          end
        end else begin
          if (ge_m32) begin
            entry_o.fmt = v[7:0];
          end else if (ge_m128) begin
            entry_o = '{fmt: msgpk_pkg::FMT_INT8, cnt: 4'd1, data: {v[7:0], 56'h0}};
          end else if (ge_m32k) begin
            entry_o = '{fmt: msgpk_pkg::FMT_INT16, cnt: 4'd2, data: {v[15:0], 48'h0}};
          end else if (ge_m2g) begin
            entry_o = '{fmt: msgpk_pkg::FMT_INT32, cnt: 4'd4, data: {v[31:0], 32'h0}};
          end else begin
            entry_o = '{fmt: msgpk_pkg::FMT_INT64, cnt: 4'd8, data: v};
          end
        end
      end
      msgpk_pkg::CMD_F32:
        entry_o = '{fmt: msgpk_pkg::FMT_F32, cnt: 4'd4, data: {v[31:0], 32'h0}};
      msgpk_pkg::CMD_STR: begin
        if (le_31) begin
          entry_o.fmt = msgpk_pkg::FIX_STR | {3'b000, v[4:0]};
        end else if (le_ff) begin
          entry_o = '{fmt: msgpk_pkg::FMT_STR8, cnt: 4'd1, data: {v[7:0], 56'h0}};
        end else if (le_ffff) begin
          entry_o = '{fmt: msgpk_pkg::FMT_STR16, cnt: 4'd2, data: {v[15:0], 48'h0}};
        end else begin
          entry_o = '{fmt: msgpk_pkg::FMT_STR32, cnt: 4'd4, data: {v[31:0], 32'h0}};
        end
      end
      msgpk_pkg::CMD_ARRAY, msgpk_pkg::CMD_MAP: begin
        if (le_15) begin
          entry_o.fmt = ((cmd_i == msgpk_pkg::CMD_ARRAY) ? msgpk_pkg::FIX_ARRAY
                                                        : msgpk_pkg::FIX_MAP)
                        | {4'h0, v[3:0]};
        end else if (le_ffff) begin
          entry_o.fmt  = (cmd_i == msgpk_pkg::CMD_ARRAY) ? msgpk_pkg::FMT_ARRAY16
                                                         : msgpk_pkg::FMT_MAP16;
          entry_o.cnt  = 4'd2;
          entry_o.data = {v[15:0], 48'h0};
        end else begin
          entry_o.fmt  = (cmd_i == msgpk_pkg::CMD_ARRAY) ? msgpk_pkg::FMT_ARRAY32
                                                         : msgpk_pkg::FMT_MAP32;
          entry_o.cnt  = 4'd4;
          entry_o.data = {v[31:0], 32'h0};
        end
      end
      msgpk_pkg::CMD_RAW:  entry_o.fmt = v[7:0];
      // unused command codes produce nothing
      default:             push_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/msgpk_fifo.sv
// Short queue of classified items between the encoder front and back.
// Depends on msgpk_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire msgpk_pkg::entry_t entry_i,
  input  wire logic              pop_i,
  output msgpk_pkg::entry_t      entry_o,
  output logic                   empty_o,
  output logic                   full_o
);

  localparam int unsigned PtrW = $clog2(msgpk_pkg::QDepth);
  localparam int unsigned CntW = $clog2(msgpk_pkg::QDepth + 1);

  msgpk_pkg::entry_t    mem_q [msgpk_pkg::QDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(msgpk_pkg::QDepth));
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(msgpk_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(msgpk_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/msgpk_back.sv
// Back end of the MessagePack encoder: serializes one queued item per
// format byte plus payload, one byte per cycle. Depends on msgpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msgpk_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire msgpk_pkg::entry_t entry_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic                   out_valid_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] data_q, data_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        valid_q, valid_d;

  // Start a new item only when the current payload is fully sent
  assign pop_o = (cnt_q == 4'd0) && !empty_i;

  always_comb begin
    cnt_d   = cnt_q;
    data_d  = data_q;
    byte_d  = byte_q;
    last_d  = 1'b0;
    valid_d = 1'b0;
    if (cnt_q != 4'd0) begin
      // next payload byte, most significant first
      byte_d  = data_q[63:56];
      data_d  = {data_q[55:0], 8'h00};
      cnt_d   = cnt_q - 4'd1;
      last_d  = (cnt_q == 4'd1);
      valid_d = 1'b1;
    end else if (pop_o) begin
      // format byte of the next item
      byte_d  = entry_i.fmt;
      data_d  = entry_i.data;
      cnt_d   = entry_i.cnt;
      last_d  = (entry_i.cnt == 4'd0);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 4'd0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    byte_q <= byte_d;
  end

  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign out_valid_o = valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/msgpack_value_encoder_top.sv
// MessagePack value encoder. An item is registered in the queue and each of
// its bytes in the byte-wide serializer's output register; the bytes of an
// item leave one byte per cycle: the format byte plus up to 8 payload bytes.
// A two-entry queue lets commands keep arriving while bytes drain; busy
// is high only when the queue is full. Unused commands produce no bytes.
// Asynchronous active-low reset empties the queue and the serializer.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_value_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [63:0] value_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  output logic             out_valid_o
);

  msgpk_pkg::entry_t front_entry, queue_entry;
  logic              push, pop, q_empty, q_full;

  assign busy = q_full;

  msgpk_front u_front (
    .take_i  (start && !busy),
    .cmd_i   (cmd_i),
    .value_i (value_i),
    .entry_o (front_entry),
    .push_o  (push)
  );

  msgpk_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  msgpk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (queue_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o)
  );

endmodule
`default_nettype wire

>>> test/msgpack_value_encoder_top_tb.sv
// Self-checking testbench for msgpack_value_encoder_top: typed values in,
// encoded bytes checked one by one. Depends on msgpk_pkg and the encoder RTL.
`timescale 1ns / 1ps
module msgpack_value_encoder_top_tb;
  import msgpk_pkg::*;

  localparam int unsigned RandItems   = 235;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 16;

  // One encoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  // Scoreboard: encodes each transferred value into the bytes it should
  // produce and matches the output stream against them in order
  class enc_scoreboard;
    enc_byte_t   exp_bytes[$];
    int unsigned errors;
    int unsigned bytes_checked;

    function new();
      errors = 0;
      bytes_checked = 0;
    endfunction

    function int unsigned pending();
      return exp_bytes.size();
    endfunction

    // Append one non-final byte to a sequence
    function void add_byte(ref enc_byte_t seq[$], input logic [7:0] data);
      enc_byte_t b;
      b.data = data;
      b.last = 1'b0;
      seq.insert(seq.size(), b);
    endfunction

    // Format byte, then the low 'cnt' bytes of v, big-endian
    function void add_form(ref enc_byte_t seq[$], input logic [7:0] fmt,
                           input logic [63:0] v, input int cnt);
      add_byte(seq, fmt);
      for (int k = cnt - 1; k >= 0; k--) begin
        add_byte(seq, v[8*k +: 8]);
      end
    endfunction

    function void add_uint(ref enc_byte_t seq[$], input logic [63:0] v);
      if (v <= 64'h7f) begin
        add_byte(seq, v[7:0]);
      end else if (v <= 64'hff) begin
        add_form(seq, FMT_UINT8, v, 1);
      end else if (v <= 64'hffff) begin
        add_form(seq, FMT_UINT16, v, 2);
      end else if (v <= 64'hffff_ffff) begin
        add_form(seq, FMT_UINT32, v, 4);
      end else begin
        add_form(seq, FMT_UINT64, v, 8);
      end
    endfunction

    // Arrays and maps share one shape; only the format bytes differ
    function void add_coll(ref enc_byte_t seq[$], input logic [63:0] n,
                           input logic [7:0] fix, input logic [7:0] fmt16,
                           input logic [7:0] fmt32);
      if (n <= 64'd15) begin
        add_byte(seq, fix | n[7:0]);
      end else if (n <= 64'hffff) begin
        add_form(seq, fmt16, n, 2);
      end else begin
        add_form(seq, fmt32, n, 4);
      end
    endfunction

    // Predict the bytes for one transferred command
    function void note_item(logic [3:0] cmd, logic [63:0] v);
      enc_byte_t seq[$];
      case (cmd)
        CMD_NIL:  add_byte(seq, FMT_NIL);
        CMD_BOOL: add_byte(seq, (v != 64'd0) ? FMT_TRUE : FMT_FALSE);
        CMD_UINT: add_uint(seq, v);
        CMD_SINT: begin
          if (!v[63]) begin
            add_uint(seq, v);
          end else if (v >= 64'hffff_ffff_ffff_ffe0) begin
            add_byte(seq, v[7:0]);
          end else if (v >= 64'hffff_ffff_ffff_ff80) begin
            add_form(seq, FMT_INT8, v, 1);
          end else if (v >= 64'hffff_ffff_ffff_8000) begin
            add_form(seq, FMT_INT16, v, 2);
          end else if (v >= 64'hffff_ffff_8000_0000) begin
            add_form(seq, FMT_INT32, v, 4);
          end else begin
            add_form(seq, FMT_INT64, v, 8);
          end
        end
        CMD_F32: add_form(seq, FMT_F32, v, 4);
        CMD_STR: begin
          if (v <= 64'd31) begin
            add_byte(seq, FIX_STR | v[7:0]);
          end else if (v <= 64'hff) begin
            add_form(seq, FMT_STR8, v, 1);
          end else if (v <= 64'hffff) begin
            add_form(seq, FMT_STR16, v, 2);
          end else begin
            add_form(seq, FMT_STR32, v, 4);
          end
        end
        CMD_ARRAY: add_coll(seq, v, FIX_ARRAY, FMT_ARRAY16, FMT_ARRAY32);
        CMD_MAP:   add_coll(seq, v, FIX_MAP, FMT_MAP16, FMT_MAP32);
        CMD_RAW:   add_byte(seq, v[7:0]);
        default: ;  // unused codes encode nothing
      endcase
      if (seq.size() != 0) begin
        seq[seq.size() - 1].last = 1'b1;
      end
      exp_bytes = {exp_bytes, seq};
    endfunction

    // Compare one output byte with the oldest prediction
    function void check_byte(logic [7:0] data, logic last);
      enc_byte_t want;
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b, nothing expected",
                 $time, data, last);
        errors++;
        return;
      end
      want = exp_bytes.pop_front();
      bytes_checked++;
      if (data !== want.data) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  cmd_i;
  logic [63:0] value_i;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        out_valid_o;

  enc_scoreboard board;
  int unsigned   items_sent;
  int unsigned   idle_cycles;
  bit            burst;

  msgpack_value_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .out_valid_o(out_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: every strobed byte is checked at the edge ending its cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      board.check_byte(out_byte_o, last_o);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("msgpack_value_encoder_top verification failed");
      $finish;
    end
  end

  // Idle time before the next command: mostly none, some short, few long
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (burst || sel < 11) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Values biased to the encoding boundaries, plus full-width noise
  function automatic logic [63:0] pick_value();
    logic [31:0] r;
    logic [63:0] v;
    r = $urandom;
    case ($urandom_range(0, 10))
      0, 1: v = {$urandom, $urandom};
      2:    v = 64'($urandom_range(0, 40));
      3:    v = {56'd0, r[7:0]};
      4:    v = {48'd0, r[15:0]};
      5:    v = {32'd0, r};
      6:    v = {56'hff_ffff_ffff_ffff, r[7:0]};
      7:    v = {48'hffff_ffff_ffff, r[15:0]};
      8:    v = {32'hffff_ffff, r};
      default: begin
        case ($urandom_range(0, 16))
          0:  v = 64'h0f;
          1:  v = 64'h1f;
          2:  v = 64'h7f;
          3:  v = 64'hff;
          4:  v = 64'hffff;
          5:  v = 64'hffff_ffff;
          6:  v = 64'hffff_ffff_ffff_ffe0;
          7:  v = 64'hffff_ffff_ffff_ff80;
          8:  v = 64'hffff_ffff_ffff_8000;
          9:  v = 64'hffff_ffff_8000_0000;
          10: v = 64'h8000_0000_0000_0000;
          11: v = 64'h7fff_ffff_ffff_ffff;
          12: v = 64'h1_0000_0000;
          13: v = 64'h10;
          14: v = 64'h20;
          15: v = 64'h80;
          default: v = 64'd0;
        endcase
        v = v + 64'($urandom_range(0, 2)) - 64'd1;
      end
    endcase
    return v;
  endfunction

  // Hold a command until it is transferred, then idle for 'gap' cycles
  task automatic send_item(input logic [3:0] cmd, input logic [63:0] value,
                           input int unsigned gap);
    start   <= 1'b1;
    cmd_i   <= cmd;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    board.note_item(cmd, value);
    items_sent++;
    if (gap != 0) begin
      // operands wiggle while start is low; the block must ignore them
      start   <= 1'b0;
      cmd_i   <= 4'($urandom);
      value_i <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [3:0]  cmd;
    logic [63:0] value;
    int unsigned rand_count;
    int unsigned body_len;

    board       = new();
    items_sent  = 0;
    burst       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = 4'd0;
    value_i     = 64'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, form boundaries and the special cases
    send_item(CMD_NIL,   64'hffff_ffff_ffff_ffff, 0);  // nil ignores value
    send_item(CMD_BOOL,  64'd0, 0);
    send_item(CMD_BOOL,  64'h8000_0000_0000_0000, 0);  // any nonzero is true
    send_item(CMD_UINT,  64'h7f, 0);
    send_item(CMD_UINT,  64'h80, 0);
    send_item(CMD_UINT,  64'h1_0000, 0);
    send_item(CMD_UINT,  64'hffff_ffff, 0);
    send_item(CMD_UINT,  64'hffff_ffff_ffff_ffff, 0);
    send_item(CMD_SINT,  64'hffff_ffff_ffff_ffe0, 0);
    send_item(CMD_SINT,  64'hffff_ffff_ffff_ffdf, 0);
    send_item(CMD_SINT,  64'hffff_ffff_ffff_7fff, 0);
    send_item(CMD_SINT,  64'hffff_ffff_7fff_ffff, 0);
    send_item(CMD_SINT,  64'h8000_0000_0000_0000, 0);
    send_item(CMD_SINT,  64'h7fff_ffff_ffff_ffff, 0);
    send_item(CMD_F32,   64'hdead_beef_3f80_0000, 0);  // upper half dropped
    send_item(CMD_STR,   64'd31, 0);
    send_item(CMD_STR,   64'h100, 0);
    send_item(CMD_STR,   64'h1234_5678_9abc, 0);       // wide length truncated
    send_item(CMD_ARRAY, 64'd16, 0);
    send_item(CMD_ARRAY, 64'hffff_0001_0000, 0);
    send_item(CMD_MAP,   64'd15, 0);
    send_item(CMD_MAP,   64'hffff_ffff_ffff_ffff, 0);
    send_item(CMD_RAW,   64'hffff_ffff_ffff_ff5a, 0);  // only low byte passes
    send_item(4'd9,      64'h55, 0);                   // unused codes: no bytes
    send_item(4'd15,     64'hffff_ffff_ffff_ffff, 3);

    // Random: mostly valid commands, strings often followed by their body
    rand_count = 0;
    while (rand_count < RandItems) begin
      if ($urandom_range(0, 29) == 0) begin
        burst = ~burst;
      end
      if ($urandom_range(0, 19) == 0) begin
        cmd = 4'($urandom_range(9, 15));
        send_item(cmd, {$urandom, $urandom}, pick_gap());
      end else begin
        cmd   = 4'($urandom_range(0, 8));
        value = pick_value();
        if (cmd == CMD_STR && $urandom_range(0, 1) == 1) begin
          body_len = $urandom_range(0, 12);
          send_item(cmd, 64'(body_len), pick_gap());
          rand_count++;
          for (int i = 0; i < body_len; i++) begin
            send_item(CMD_RAW, {$urandom, $urandom}, pick_gap());
            rand_count++;
          end
        end else begin
          send_item(cmd, value, pick_gap());
          rand_count++;
        end
      end
    end
    start <= 1'b0;

    // Drain: all predicted bytes out, then a quiet tail for strays
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d predicted bytes never arrived", $time, board.pending());
      board.errors += board.pending();
    end

    $display("Sent %0d commands (all nine encodings, unused codes, string bodies),",
             items_sent);
    $display("checked %0d output bytes, %0d errors", board.bytes_checked, board.errors);
    if (board.errors == 0) begin
      $display("msgpack_value_encoder_top verification clean");
    end else begin
      $display("msgpack_value_encoder_top verification failed");
    end
    $finish;
  end

endmodule
